// File: hdl/rmtl_pkg.sv
`default_nettype none

package rmtl_pkg;

  // Field widths of one request and one result
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned LETTER_W = 8;
  localparam int unsigned TIME_W   = 31;
  localparam int unsigned IDX_W    = 6;

  // Request kinds; codes six and seven are no-ops
  typedef enum logic [KIND_W-1:0] {
    KIND_QUERY  = 3'd0,
    KIND_MARK   = 3'd1,
    KIND_CLRNEW = 3'd2,
    KIND_CLRALL = 3'd3,
    KIND_LOAD   = 3'd4,
    KIND_READ   = 3'd5
  } kind_t;

  // Name letters for which mark-read and clear-new act
  localparam logic [LETTER_W-1:0] LETTER_M = 8'h4D;
  localparam logic [LETTER_W-1:0] LETTER_G = 8'h47;

endpackage

`default_nettype wire

// File: hdl/rmtl_if.sv
`default_nettype none

// Request channel: one operation on the list
interface rmtl_req_if import rmtl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [LETTER_W-1:0] name_letter;
  logic [TIME_W-1:0]   time_value;
  logic [IDX_W-1:0]    entry_index;

  modport source (output valid, kind, name_letter, time_value, entry_index, input ready);
  modport sink   (input valid, kind, name_letter, time_value, entry_index, output ready);
endinterface

// Result channel: one result per request
interface rmtl_rsp_if import rmtl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              unread;
  logic [TIME_W-1:0] entry_value;
  logic              dirty;

  modport source (output valid, unread, entry_value, dirty, input ready);
  modport sink   (input valid, unread, entry_value, dirty, output ready);
endinterface

`default_nettype wire

// File: hdl/rmtl_mem.sv
`default_nettype none

// List storage: one write and one registered read per cycle.
// Entries never written since reset read as zero through per-entry valid bits.
module rmtl_mem import rmtl_pkg::*; #(
  parameter int unsigned DEPTH = 50,
  parameter int unsigned AW    = 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [TIME_W-1:0] wr_data,
  output logic      [TIME_W-1:0] rd_data
);

  logic [TIME_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [TIME_W-1:0] rd_q;
  logic              rd_vld;

  // Data array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Valid bits, cleared at once by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

// File: hdl/rmtl_ctrl.sv
`default_nettype none

// Sequencer: walks the list through the memory read port, one entry a cycle,
// and applies inserts, cuts, fills and single-entry writes and reads.
module rmtl_ctrl import rmtl_pkg::*; #(
  parameter int unsigned LIST_LEN = 50,
  parameter int unsigned AW       = 6,
  parameter int unsigned PW       = 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  rmtl_req_if.sink               req,
  rmtl_rsp_if.source             rsp,
  output logic                   rd_en,
  output logic      [AW-1:0]     rd_addr,
  output logic                   wr_en,
  output logic      [AW-1:0]     wr_addr,
  output logic      [TIME_W-1:0] wr_data,
  input  wire logic [TIME_W-1:0] rd_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_RIPPLE, S_FILL, S_CLR0, S_WR2, S_LOAD, S_RDREQ, S_RDWAIT, S_DONE
  } state_t;

  state_t              state, state_next;
  kind_t               kind, kind_next;
  logic [TIME_W-1:0]   tval, tval_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [PW-1:0]       ptr, ptr_next;
  logic                pend, pend_next;
  logic [TIME_W-1:0]   carry, carry_next;
  logic                res_unread, res_unread_next;
  logic [TIME_W-1:0]   res_value, res_value_next;
  logic                dirty, dirty_next;
  logic                out_valid, out_valid_next;
  logic                out_unread, out_unread_next;
  logic [TIME_W-1:0]   out_value, out_value_next;
  logic                out_dirty, out_dirty_next;

  logic                letter_ok;
  logic                idx_ok;
  logic                at_end;
  logic                first;
  logic                is_zero;
  logic                t_gt;
  logic                t_eq;
  logic [AW-1:0]       prev_addr;

  assign letter_ok = (req.name_letter == LETTER_M) || (req.name_letter == LETTER_G);
  assign idx_ok    = 32'(idx) < 32'(LIST_LEN);
  assign at_end    = ptr == PW'(LIST_LEN);
  assign first     = ptr == PW'(1);
  assign is_zero   = rd_data == '0;
  assign t_gt      = tval > rd_data;
  assign t_eq      = tval == rd_data;
  assign prev_addr = AW'(ptr - PW'(1));

  assign req.ready       = state == S_IDLE;
  assign rsp.valid       = out_valid;
  assign rsp.unread      = out_unread;
  assign rsp.entry_value = out_value;
  assign rsp.dirty       = out_dirty;

  // Next-state and memory port logic
  always_comb begin
    state_next      = state;
    kind_next       = kind;
    tval_next       = tval;
    idx_next        = idx;
    ptr_next        = ptr;
    pend_next       = 1'b0;
    carry_next      = carry;
    res_unread_next = res_unread;
    res_value_next  = res_value;
    dirty_next      = dirty;
    out_valid_next  = out_valid && !rsp.ready;
    out_unread_next = out_unread;
    out_value_next  = out_value;
    out_dirty_next  = out_dirty;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          kind_next       = kind_t'(req.kind);
          tval_next       = req.time_value;
          idx_next        = req.entry_index;
          ptr_next        = '0;
          res_unread_next = 1'b0;
          res_value_next  = '0;
          unique case (kind_t'(req.kind)) inside
            KIND_QUERY:              state_next = S_WALK;
            KIND_MARK, KIND_CLRNEW:  state_next = letter_ok ? S_WALK : S_DONE;
            KIND_CLRALL:             state_next = S_CLR0;
            KIND_LOAD:               state_next = S_LOAD;
            KIND_READ:               state_next = S_RDREQ;
            default:                 state_next = S_DONE;
          endcase
        end
      end

      // Stream reads; data of entry ptr-1 arrives while entry ptr is read
      S_WALK: begin
        if (!at_end) begin
          rd_en     = 1'b1;
          rd_addr   = ptr[AW-1:0];
          ptr_next  = ptr + PW'(1);
          pend_next = 1'b1;
        end
        if (pend) begin
          case (kind)
            KIND_QUERY: begin
              if (is_zero) begin
                res_unread_next = first;
                state_next      = S_DONE;
              end else if (t_gt) begin
                res_unread_next = 1'b1;
                state_next      = S_DONE;
              end else if (t_eq || at_end) begin
                state_next = S_DONE;
              end
            end
            KIND_MARK: begin
              if (is_zero) begin
                // empty list gets filled, otherwise the time is below every entry
                ptr_next   = '0;
                state_next = first ? S_FILL : S_DONE;
              end else if (t_gt) begin
                // insert here, then ripple the tail down by one
                wr_en      = 1'b1;
                wr_addr    = prev_addr;
                wr_data    = tval;
                carry_next = rd_data;
                dirty_next = 1'b1;
                state_next = at_end ? S_DONE : S_RIPPLE;
              end else if (t_eq || at_end) begin
                state_next = S_DONE;
              end
            end
            KIND_CLRNEW: begin
              if (is_zero || t_gt || t_eq) begin
                wr_en      = 1'b1;
                wr_addr    = prev_addr;
                wr_data    = tval;
                dirty_next = 1'b1;
                ptr_next   = ptr;
                state_next = at_end ? S_DONE : S_WR2;
              end else if (at_end) begin
                state_next = S_DONE;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end

      // Each entry takes the value of the one above it
      S_RIPPLE: begin
        wr_en      = 1'b1;
        wr_addr    = prev_addr;
        wr_data    = carry;
        carry_next = rd_data;
        if (at_end) begin
          state_next = S_DONE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = ptr[AW-1:0];
          ptr_next = ptr + PW'(1);
        end
      end

      // Fill all but the last entry with the time; last becomes the terminator
      S_FILL: begin
        wr_en   = 1'b1;
        wr_addr = ptr[AW-1:0];
        if (ptr == PW'(LIST_LEN - 1)) begin
          wr_data    = '0;
          dirty_next = 1'b1;
          state_next = S_DONE;
        end else begin
          wr_data  = tval;
          ptr_next = ptr + PW'(1);
        end
      end

      S_CLR0: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = tval;
        dirty_next = 1'b1;
        ptr_next   = PW'(1);
        state_next = S_WR2;
      end

      // Terminator after the entry just written
      S_WR2: begin
        wr_en      = 1'b1;
        wr_addr    = ptr[AW-1:0];
        wr_data    = '0;
        state_next = S_DONE;
      end

      S_LOAD: begin
        if (idx_ok) begin
          wr_en      = 1'b1;
          wr_addr    = AW'(idx);
          wr_data    = tval;
          dirty_next = 1'b0;
        end
        state_next = S_DONE;
      end

      S_RDREQ: begin
        if (idx_ok) begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx);
        end
        state_next = S_RDWAIT;
      end

      S_RDWAIT: begin
        res_value_next = idx_ok ? rd_data : '0;
        state_next     = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_unread_next = res_unread;
          out_value_next  = res_value;
          out_dirty_next  = dirty;
          state_next      = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      ptr       <= '0;
      dirty     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pend      <= pend_next;
      ptr       <= ptr_next;
      dirty     <= dirty_next;
      out_valid <= out_valid_next;
    end
    kind       <= kind_next;
    tval       <= tval_next;
    idx        <= idx_next;
    carry      <= carry_next;
    res_unread <= res_unread_next;
    res_value  <= res_value_next;
    out_unread <= out_unread_next;
    out_value  <= out_value_next;
    out_dirty  <= out_dirty_next;
  end

endmodule

`default_nettype wire

// File: hdl/read_mark_timestamp_list.sv
`default_nettype none

// Channel  Dir  Fields
// req      in   kind, name_letter, time_value, entry_index
// rsp      out  unread, entry_value, dirty
//
// A query, mark-read or clear-new walks one entry a cycle, with an insert
// rippling the tail in the same pass; filling an empty list writes every
// entry in turn. Clear-all writes the first entry and its terminator, load
// writes and read fetches a single entry, and a no-op goes straight to rsp.
// Reset clears the list (valid bits) and the dirty mark.
// A new request is taken while an earlier result waits; its result holds
// until rsp is free.
module read_mark_timestamp_list import rmtl_pkg::*; #(
  parameter int unsigned LIST_LEN = 50
) (
  input wire logic   clk,
  input wire logic   rst,
  rmtl_req_if.sink   req,
  rmtl_rsp_if.source rsp
);

  localparam int unsigned AW = $clog2(LIST_LEN);
  localparam int unsigned PW = $clog2(LIST_LEN + 1);

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [TIME_W-1:0] wr_data;
  logic [TIME_W-1:0] rd_data;

  rmtl_ctrl #(
    .LIST_LEN (LIST_LEN),
    .AW       (AW),
    .PW       (PW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  rmtl_mem #(
    .DEPTH (LIST_LEN),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

// File: sim/read_mark_timestamp_list_chk.sv
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow copy of the timestamp list and
// compares every result against the value expected for its request.
module read_mark_timestamp_list_chk import rmtl_pkg::*; #(
  parameter int unsigned LIST_LEN = 50
) (
  input wire logic clk,
  input wire logic rst,
  rmtl_req_if      req,
  rmtl_rsp_if      rsp,
  output int       mismatches,
  output int       pending_results
);

  typedef struct packed {
    logic              unread;
    logic [TIME_W-1:0] entry_value;
    logic              dirty;
  } list_result_t;

  // Shadow state
  logic [TIME_W-1:0] marks [LIST_LEN];
  logic              list_dirty;
  list_result_t      expected_q [$];
  int                result_idx;

  function automatic logic letter_ok(logic [LETTER_W-1:0] letter);
    return letter == LETTER_M || letter == LETTER_G;
  endfunction

  // Walk the list; first zero ends it (empty list means unread)
  function automatic logic lookup_unread(logic [TIME_W-1:0] t);
    for (int n = 0; n < LIST_LEN; n++) begin
      if (marks[n] == '0) return (n == 0);
      if (t > marks[n]) return 1'b1;
      if (t == marks[n]) return 1'b0;
    end
    return 1'b0;
  endfunction

  // Ordered insert; an empty list gets filled with the time
  function automatic void insert_mark(logic [TIME_W-1:0] t);
    int n;
    n = 0;
    while (n < LIST_LEN && marks[n] != '0) begin
      if (t == marks[n]) return;
      if (t > marks[n]) begin
        for (int i = LIST_LEN - 1; i > n; i--) marks[i] = marks[i-1];
        marks[n]   = t;
        list_dirty = 1'b1;
        return;
      end
      n++;
    end
    if (n == 0) begin
      for (int i = 0; i < LIST_LEN - 1; i++) marks[i] = t;
      marks[LIST_LEN-1] = '0;
      list_dirty        = 1'b1;
    end
  endfunction

  // Write the time over the first entry it is not below, then cut the list after it
  function automatic void cut_list(logic [TIME_W-1:0] t);
    int n;
    n = 0;
    while (n < LIST_LEN && marks[n] != '0 && t < marks[n]) n++;
    if (n < LIST_LEN) begin
      marks[n] = t;
      if (n + 1 < LIST_LEN) marks[n+1] = '0;
      list_dirty = 1'b1;
    end
  endfunction

  function automatic list_result_t apply_request(logic [KIND_W-1:0] kind,
                                                 logic [LETTER_W-1:0] letter,
                                                 logic [TIME_W-1:0] t,
                                                 logic [IDX_W-1:0] idx);
    list_result_t res;
    res = '0;
    case (kind)
      KIND_QUERY: res.unread = lookup_unread(t);
      KIND_MARK: begin
        if (letter_ok(letter)) insert_mark(t);
      end
      KIND_CLRNEW: begin
        if (letter_ok(letter)) cut_list(t);
      end
      KIND_CLRALL: begin
        marks[0]   = t;
        marks[1]   = '0;
        list_dirty = 1'b1;
      end
      KIND_LOAD: begin
        if (idx < LIST_LEN) begin
          marks[idx] = t;
          list_dirty = 1'b0;
        end
      end
      KIND_READ: begin
        if (idx < LIST_LEN) res.entry_value = marks[idx];
      end
      default: ;
    endcase
    res.dirty = list_dirty;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
    mismatches++;
    $display("%0t: result %0d: %s: got %0h, want %0h", $realtime, result_idx, what,
             got, want);
  endtask

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin : watch
    list_result_t want;
    if (rst) begin
      foreach (marks[i]) marks[i] = '0;
      list_dirty = 1'b0;
      expected_q.delete();
    end else begin
      if (req.valid && req.ready)
        expected_q.push_back(apply_request(req.kind, req.name_letter, req.time_value,
                                           req.entry_index));
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no request waiting", rsp.entry_value, '0);
        end else begin
          want = expected_q.pop_front();
          if (rsp.unread !== want.unread)
            report_mismatch("unread", TIME_W'(rsp.unread), TIME_W'(want.unread));
          if (rsp.entry_value !== want.entry_value)
            report_mismatch("entry_value", rsp.entry_value, want.entry_value);
          if (rsp.dirty !== want.dirty)
            report_mismatch("dirty", TIME_W'(rsp.dirty), TIME_W'(want.dirty));
        end
        result_idx++;
      end
    end
    pending_results <= expected_q.size();
  end

endmodule

// File: sim/read_mark_timestamp_list_tb.sv
`timescale 1ns / 1ps

module read_mark_timestamp_list_tb;
  import rmtl_pkg::*;

  localparam int unsigned LIST_LEN    = 50;
  localparam int          PHASE_ITEMS = 300;
  localparam int          DRAIN_WAIT  = 2 * LIST_LEN + 20;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam logic [TIME_W-1:0]   TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [KIND_W-1:0]   KIND_NOP6 = 3'd6;
  localparam logic [KIND_W-1:0]   KIND_NOP7 = 3'd7;
  localparam logic [LETTER_W-1:0] LETTER_A  = "A";
  localparam logic [LETTER_W-1:0] LETTER_X  = "x";

  logic clk;
  logic rst;
  int   snd_idle;
  int   rcv_idle;
  int   cycles;
  int   mismatches;
  int   pending_results;

  rmtl_req_if req_ch ();
  rmtl_rsp_if rsp_ch ();

  read_mark_timestamp_list #(.LIST_LEN(LIST_LEN)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  read_mark_timestamp_list_chk #(.LIST_LEN(LIST_LEN)) list_chk (
    .clk             (clk),
    .rst             (rst),
    .req             (req_ch),
    .rsp             (rsp_ch),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Issue one request after a random gap; holds until accepted
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [LETTER_W-1:0] letter,
                              input logic [TIME_W-1:0] t,
                              input logic [IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < snd_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.kind        <= kind;
    req_ch.name_letter <= letter;
    req_ch.time_value  <= t;
    req_ch.entry_index <= idx;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Mostly marks and queries in a narrow time window so that entries collide
  // and the list fills; the rest is wide times, odd letters and bad indexes.
  task automatic send_random_request();
    int                  sel;
    int                  tsel;
    logic [KIND_W-1:0]   kind;
    logic [LETTER_W-1:0] letter;
    logic [TIME_W-1:0]   t;
    logic [IDX_W-1:0]    idx;
    sel  = $urandom_range(0, 99);
    tsel = $urandom_range(0, 99);
    if (sel < 30)      kind = KIND_QUERY;
    else if (sel < 60) kind = KIND_MARK;
    else if (sel < 70) kind = KIND_CLRNEW;
    else if (sel < 74) kind = KIND_CLRALL;
    else if (sel < 82) kind = KIND_LOAD;
    else if (sel < 95) kind = KIND_READ;
    else if (sel < 97) kind = ($urandom_range(0, 1) != 0) ? KIND_NOP6 : KIND_NOP7;
    else               kind = KIND_MARK;
    if (tsel < 82)      t = TIME_W'($urandom_range(1, 400));
    else if (tsel < 97) t = TIME_W'($urandom());
    else if (tsel < 98) t = '0;
    else                t = TIME_MAX;
    if ($urandom_range(0, 99) < 85)
      letter = ($urandom_range(0, 1) != 0) ? LETTER_M : LETTER_G;
    else
      letter = LETTER_W'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 80) idx = IDX_W'($urandom_range(0, LIST_LEN - 1));
    else                            idx = IDX_W'($urandom_range(0, 63));
    send_request(kind, letter, t, idx);
  endtask

  // Hold the request side low until every result is back
  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  initial begin
    snd_idle           = 18;
    rcv_idle           = 59;
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.kind        <= KIND_QUERY;
    req_ch.name_letter <= '0;
    req_ch.time_value  <= '0;
    req_ch.entry_index <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list, ignored letters, fill, full list, cuts, loads, reads, no-ops, clear-all
    send_request(KIND_QUERY, LETTER_M, 31'd5, '0);
    send_request(KIND_READ, LETTER_M, '0, 6'd0);
    send_request(KIND_MARK, LETTER_A, 31'd100, '0);
    send_request(KIND_CLRNEW, LETTER_X, 31'd100, '0);
    send_request(KIND_MARK, LETTER_M, 31'd100, '0);
    send_request(KIND_READ, LETTER_M, '0, 6'd48);
    send_request(KIND_READ, LETTER_M, '0, 6'd49);
    send_request(KIND_MARK, LETTER_G, 31'd100, '0);
    send_request(KIND_MARK, LETTER_M, 31'd50, '0);
    send_request(KIND_MARK, LETTER_G, 31'd200, '0);
    send_request(KIND_QUERY, LETTER_M, 31'd50, '0);
    send_request(KIND_QUERY, LETTER_M, TIME_MAX, '0);
    send_request(KIND_QUERY, LETTER_M, 31'd100, '0);
    send_request(KIND_CLRNEW, LETTER_M, 31'd10, '0);
    send_request(KIND_CLRNEW, LETTER_G, 31'd150, '0);
    send_request(KIND_QUERY, LETTER_G, 31'd120, '0);
    send_request(KIND_LOAD, LETTER_M, TIME_MAX, 6'd49);
    send_request(KIND_LOAD, LETTER_M, 31'd7, 6'd50);
    send_request(KIND_LOAD, LETTER_M, 31'd7, 6'd63);
    send_request(KIND_READ, LETTER_M, '0, 6'd49);
    send_request(KIND_READ, LETTER_M, '0, 6'd63);
    send_request(KIND_NOP6, 8'hFF, TIME_MAX, 6'd63);
    send_request(KIND_NOP7, 8'h00, '0, 6'd0);
    send_request(KIND_CLRALL, LETTER_M, TIME_MAX, '0);
    send_request(KIND_CLRALL, LETTER_M, '0, '0);
    send_request(KIND_MARK, LETTER_M, '0, '0);

    // Random traffic in three idling phases, drained between them
    for (int phase = 0; phase < 3; phase++) begin
      wait_all_results();
      snd_idle = (phase == 0) ? 18 : (phase == 1) ? 59 : 0;
      rcv_idle = (phase == 0) ? 59 : (phase == 1) ? 18 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_request();
    end

    wait_all_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
